>>> src/pss_pkg.sv
package pss_pkg;

    // Step table geometry.
    localparam int MAX_STEPS = 128;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);

    // Field widths.
    localparam int PHASE_W   = 16;
    localparam int VALUE_W   = 16;
    localparam int PROB_W    = 17;
    localparam int RATCHET_W = 4;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 64;
    localparam int ROW_W     = VALUE_W + PROB_W + RATCHET_W;

    // Input item kinds carried on tuser.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_COUNT     = 3'd0,
        CFG_CHANNEL        = 3'd1,
        CFG_VALUE_LENGTH   = 3'd2,
        CFG_PROB_LENGTH    = 3'd3,
        CFG_RATCHET_LENGTH = 3'd4
    } t_cfg_index;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick_load;
        logic table_write;
        logic step_load;
        logic eval;
    } t_pss_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_pss_status;

endpackage

>>> src/pss_ram.sv
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pss_ctrl.sv
module pss_ctrl
    import pss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tuser,
    input  t_pss_status i_status,
    output logic        o_s_tready,
    output t_pss_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_READ = 4'b0100,
        S_EVAL = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (t_opcode'(i_s_tuser) == OP_TICK) begin
                        o_cmd.tick_load = 1'b1;
                        n_state         = S_MUL;
                    end else begin
                        o_cmd.table_write = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.step_load = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!i_status.out_busy) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

>>> src/pss_datapath.sv
module pss_datapath
    import pss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pss_cmd             i_cmd,
    output t_pss_status          o_status,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [IN_W-1:0]      i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata
);

    localparam logic [PROB_W-1:0]    PROB_ONE      = PROB_W'(65536);
    localparam logic [7:0]           NOTE_ON_BASE  = 8'h90;
    localparam logic [7:0]           NOTE_OFF_BASE = 8'h80;
    localparam logic [6:0]           VELOCITY      = 7'd100;
    localparam logic [RATCHET_W-1:0] RATCHET_MAX   = RATCHET_W'(8);
    localparam logic [31:0]          RNG_SEED      = 32'hA5C31E59;
    localparam int                   PROD_W        = PHASE_W + CNT_W;

    function automatic logic [31:0] xorshift(input logic [31:0] w);
        logic [31:0] r;
        r = w;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        return r;
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_step_count;
    logic [4:0]       r_channel;
    logic [CFG_W-1:0] r_value_length;
    logic [CFG_W-1:0] r_prob_length;
    logic [CFG_W-1:0] r_ratchet_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count     <= CFG_W'(8);
            r_channel        <= 5'd1;
            r_value_length   <= '0;
            r_prob_length    <= '0;
            r_ratchet_length <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STEP_COUNT:     r_step_count     <= i_cfg_data;
                CFG_CHANNEL:        r_channel        <= i_cfg_data[4:0];
                CFG_VALUE_LENGTH:   r_value_length   <= i_cfg_data;
                CFG_PROB_LENGTH:    r_prob_length    <= i_cfg_data;
                CFG_RATCHET_LENGTH: r_ratchet_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input field split.
    logic [PHASE_W-1:0]   in_phase;
    logic                 in_rlevel;
    logic [6:0]           in_index;
    logic [VALUE_W-1:0]   in_value;
    logic [PROB_W-1:0]    in_prob;
    logic [RATCHET_W-1:0] in_ratchet;

    assign in_phase   = i_s_tdata[15:0];
    assign in_rlevel  = i_s_tdata[16];
    assign in_index   = i_s_tdata[23:17];
    assign in_value   = i_s_tdata[39:24];
    assign in_prob    = i_s_tdata[56:40];
    assign in_ratchet = i_s_tdata[60:57];

    // Table row write with clamping of probability and ratchet count.
    logic [PROB_W-1:0]    wr_prob;
    logic [RATCHET_W-1:0] wr_ratchet;
    logic                 wr_en;
    logic [STEP_W-1:0]    wr_addr;

    always_comb begin
        wr_prob    = (in_prob > PROB_ONE) ? PROB_ONE : in_prob;
        wr_ratchet = in_ratchet;
        if (wr_ratchet < RATCHET_W'(1)) begin
            wr_ratchet = RATCHET_W'(1);
        end
        if (wr_ratchet > RATCHET_MAX) begin
            wr_ratchet = RATCHET_MAX;
        end
        wr_en   = i_cmd.table_write && (32'(in_index) < 32'(MAX_STEPS));
        wr_addr = STEP_W'(in_index);
    end

    logic [STEP_W-1:0] r_step;
    logic [ROW_W-1:0]  rd_row;

    pss_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({wr_ratchet, wr_prob, in_value}),
        .i_raddr (r_step),
        .o_rdata (rd_row)
    );

    // Phase offset capture, adjusted phase and active step count.
    logic               r_last_rlevel;
    logic [PHASE_W-1:0] r_phase_offset;
    logic [PHASE_W-1:0] r_adj;
    logic [CNT_W-1:0]   r_n;
    logic [PHASE_W-1:0] n_offset;
    logic [15:0]        n_wide;

    always_comb begin
        n_offset = (in_rlevel && !r_last_rlevel) ? in_phase : r_phase_offset;
        n_wide   = (r_step_count < r_value_length) ? 16'(r_step_count)
                                                   : 16'(r_value_length);
        if (n_wide > 16'(MAX_STEPS)) begin
            n_wide = 16'(MAX_STEPS);
        end
        if (n_wide == 16'd0) begin
            n_wide = 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rlevel  <= 1'b0;
            r_phase_offset <= '0;
        end else if (i_cmd.tick_load) begin
            r_last_rlevel  <= in_rlevel;
            r_phase_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_load) begin
            r_adj <= in_phase - n_offset;
            r_n   <= CNT_W'(n_wide);
        end
    end

    // Step selection: adjusted phase times step count.
    logic [PROD_W-1:0]  scaled;
    logic [CNT_W-1:0]   step_raw;
    logic [CNT_W-1:0]   n_last;
    logic [PHASE_W-1:0] r_frac;

    always_comb begin
        scaled   = PROD_W'(r_adj) * PROD_W'(r_n);
        step_raw = scaled[PROD_W-1:PHASE_W];
        n_last   = r_n - CNT_W'(1);
        if (step_raw > n_last) begin
            step_raw = n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_load) begin
            r_step <= STEP_W'(step_raw);
            r_frac <= scaled[PHASE_W-1:0];
        end
    end

    // Step change, probability gate, ratchet latch and note generation.
    logic                 r_last_step_valid;
    logic [STEP_W-1:0]    r_last_step;
    logic                 r_active;
    logic [RATCHET_W-1:0] r_ratchet_count;
    logic                 r_slot_valid;
    logic [2:0]           r_last_slot;
    logic [31:0]          r_random;
    logic                 r_note_valid;
    logic [6:0]           r_last_note;

    logic [VALUE_W-1:0]   rd_value;
    logic [PROB_W-1:0]    rd_prob;
    logic [RATCHET_W-1:0] rd_ratchet;
    logic [15:0]          step_w;
    logic                 step_change;
    logic [PROB_W-1:0]    prob;
    logic [31:0]          rnd_next;
    logic                 rnd_advance;
    logic                 n_active;
    logic [RATCHET_W-1:0] n_rc;
    logic                 slot_valid_in;
    logic [19:0]          slot_prod;
    logic [RATCHET_W-1:0] slot;
    logic                 new_slot;
    logic                 trigger;
    logic [VALUE_W-1:0]   value;
    logic [6:0]           note;
    logic [3:0]           chan;

    always_comb begin
        rd_value    = rd_row[VALUE_W-1:0];
        rd_prob     = rd_row[VALUE_W+PROB_W-1:VALUE_W];
        rd_ratchet  = rd_row[ROW_W-1:VALUE_W+PROB_W];
        step_w      = 16'(r_step);
        step_change = !r_last_step_valid || (r_step != r_last_step);

        prob = PROB_ONE;
        if (step_w < 16'(r_prob_length)) begin
            prob = (rd_prob > PROB_ONE) ? PROB_ONE : rd_prob;
        end
        rnd_next    = xorshift(r_random);
        rnd_advance = step_change && (prob < PROB_ONE);
        n_active    = r_active;
        if (step_change) begin
            n_active = (prob >= PROB_ONE) || (PROB_W'(rnd_next[31:16]) < prob);
        end

        n_rc = r_ratchet_count;
        if (step_change) begin
            n_rc = RATCHET_W'(1);
            if (step_w < 16'(r_ratchet_length)) begin
                n_rc = rd_ratchet;
            end
            if (n_rc < RATCHET_W'(1)) begin
                n_rc = RATCHET_W'(1);
            end
            if (n_rc > RATCHET_MAX) begin
                n_rc = RATCHET_MAX;
            end
        end
        slot_valid_in = r_slot_valid && !step_change;

        // Ratchet subdivision within the step.
        slot_prod = 20'(r_frac) * 20'(n_rc);
        slot      = slot_prod[19:16];
        if (slot > n_rc - RATCHET_W'(1)) begin
            slot = n_rc - RATCHET_W'(1);
        end
        new_slot = !slot_valid_in || (slot != {1'b0, r_last_slot});
        trigger  = n_active && new_slot;

        value = '0;
        if (n_active && (step_w < 16'(r_value_length))) begin
            value = rd_value;
        end
        note = value[15] ? 7'd0 : value[14:8];
        chan = 4'(r_channel - 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_step_valid <= 1'b0;
            r_last_step       <= '0;
            r_active          <= 1'b1;
            r_ratchet_count   <= RATCHET_W'(1);
            r_slot_valid      <= 1'b0;
            r_last_slot       <= '0;
            r_random          <= RNG_SEED;
            r_note_valid      <= 1'b0;
            r_last_note       <= '0;
        end else if (i_cmd.eval) begin
            r_last_step_valid <= 1'b1;
            r_last_step       <= r_step;
            r_active          <= n_active;
            r_ratchet_count   <= n_rc;
            if (rnd_advance) begin
                r_random <= rnd_next;
            end
            r_slot_valid <= slot_valid_in || new_slot;
            if (new_slot) begin
                r_last_slot <= 3'(slot);
            end
            if (trigger) begin
                r_note_valid <= 1'b1;
                r_last_note  <= note;
            end
        end
    end

    // Output register; it holds one result until it is taken.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             off_valid;

    assign off_valid = trigger && r_note_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.eval) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_data <= {
                1'b0,
                trigger   ? VELOCITY : 7'd0,
                trigger   ? note : 7'd0,
                trigger   ? (NOTE_ON_BASE | {4'd0, chan}) : 8'd0,
                trigger,
                off_valid ? r_last_note : 7'd0,
                off_valid ? (NOTE_OFF_BASE | {4'd0, chan}) : 8'd0,
                off_valid,
                trigger,
                7'(r_step),
                value
            };
        end
    end

    assign o_status.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;

endmodule

>>> src/probabilistic_step_sequencer.sv
// Step sequencer driven by a beat phase, with per-step probability and
// ratchets. A transfer with tuser high writes one row of the value,
// probability and ratchet tables and gives no result. A transfer with
// tuser low is a tick: it captures the phase offset on a rising reset
// level, picks the step from the adjusted phase times the active step
// count, gates a new step by a 32-bit xorshift draw and emits one result
// with the step value, a trigger and the legato MIDI note-off and note-on.
// A tick passes through the accept, step multiply, table read and evaluate
// states; a full output register holds the block in the evaluate state until
// the result is taken. Configuration registers are written through the
// write-enable port while the block is idle, which the user must keep to, as
// the block does not enforce it; the tables need no clearing after reset,
// but must be written before the steps they cover are played.
module probabilistic_step_sequencer
    import pss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration writes.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: phase[15:0], reset_level[16], entry_index[23:17],
    // entry_value[39:24], entry_prob[56:40], entry_ratchet[60:57], zero[63:61]
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    // tuser: opcode[0]
    input  logic                 i_s_axis_tuser,
    // Result stream.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: step_value[15:0], step_index[22:16], trigger[23],
    // note_off_valid[24], note_off_status[32:25], note_off_number[39:33],
    // note_on_valid[40], note_on_status[48:41], note_on_number[55:49],
    // note_on_velocity[62:56], zero[63]
    output logic [OUT_W-1:0]     o_m_axis_tdata
);

    t_pss_cmd    cmd;
    t_pss_status status;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tuser  (i_s_axis_tuser),
        .i_status   (status),
        .o_s_tready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    pss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata)
    );

    // A tick keeps the input side closed for the cycles that follow it.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == OP_TICK))
        |=> !o_s_axis_tready)
        else $error("input accepted right after a tick");

    // Every trigger carries a note-on, and a note-on only comes with a trigger.
    a_trig_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[23] == o_m_axis_tdata[40]))
        else $error("trigger and note-on disagree");

    // A legato note-off never stands without its note-on.
    a_off_with_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[24]) |-> o_m_axis_tdata[40])
        else $error("note-off without note-on");

endmodule
